// File: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, command and status codes, and transaction types.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH       = 16;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [1:0] ST_ADDED   = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_REMOVED = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] item_value;
      logic        [7:0]  item_priority;
   } spq_req_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic signed [31:0] out_value;
      logic        [7:0]  out_priority;
   } spq_rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic        [7:0]  prio;
   } spq_entry_type;

   typedef struct packed {
      logic          enq;
      logic          deq;
      spq_entry_type item;
   } spq_ctl_type;

endpackage

// File: design/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; keeps, loads the new item, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
   input  logic          clock,
   input  spq_ctl_type   ctl,
   input  logic          occ,
   input  logic          left_keep,
   input  spq_entry_type left_entry,
   input  spq_entry_type right_entry,
   output logic          keep,
   output spq_entry_type entry
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;

   assign keep  = occ && (entry_ff.prio > ctl.item.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.enq) begin
         if (!keep) begin
            entry_in = left_keep ? ctl.item : left_entry;
         end
      end else if (ctl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: design/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Bounded queue of value/priority entries kept sorted, highest first.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a transaction by raising start with req_item; it is taken at any
//   rising edge where start is high and busy is low. busy stays low, so one
//   transaction may be issued every cycle. cmd enqueue inserts the item ahead
//   of all entries of lower or equal priority; cmd dequeue removes the head.
//   Every transaction returns exactly one result on rsp_item, marked by a
//   one-cycle rsp_valid pulse in the cycle after it is taken.
//   Status reports added, full (refused), removed, or empty.
//   Throughput is one transaction per cycle: a row of DEPTH cells compares
//   the new priority in parallel and shifts entries one slot per cycle.
//   Reset empties the queue at once; no clearing pass is needed.
//   The receiver cannot stall; each result must be taken when shown.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit import spq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  spq_req_type req_item,
   output logic        rsp_valid,
   output spq_rsp_type rsp_item
);

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   spq_rsp_type            rsp_item_ff;
   spq_rsp_type            rsp_item_in;

   spq_ctl_type    ctl;
   spq_entry_type  ent [DEPTH];
   logic [DEPTH-1:0] keep;
   logic [DEPTH-1:0] occ;
   logic           accept;
   logic           full;
   logic           empty;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == COUNT_WIDTH'(DEPTH));
   assign empty  = (count_ff == '0);

   assign ctl.enq       = accept && (req_item.cmd == CMD_ENQUEUE) && !full;
   assign ctl.deq       = accept && (req_item.cmd == CMD_DEQUEUE) && !empty;
   assign ctl.item.value = req_item.item_value;
   assign ctl.item.prio  = req_item.item_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_entry_type left_entry;
      spq_entry_type right_entry;
      logic          left_keep;

      assign occ[i] = (COUNT_WIDTH'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = ctl.item;
      end else begin : g_body
         assign left_keep  = keep[i-1];
         assign left_entry = ent[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = ent[i];
      end else begin : g_inner
         assign right_entry = ent[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occ         (occ[i]),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (keep[i]),
         .entry       (ent[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.enq) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (ctl.deq) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      rsp_valid_in = accept;
      rsp_item_in  = '0;
      if (req_item.cmd == CMD_ENQUEUE) begin
         rsp_item_in.status = full ? ST_FULL : ST_ADDED;
      end else if (empty) begin
         rsp_item_in.status = ST_EMPTY;
      end else begin
         rsp_item_in.status       = ST_REMOVED;
         rsp_item_in.out_value    = ent[0].value;
         rsp_item_in.out_priority = ent[0].prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("entry count exceeds depth");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy))
      else $error("result without a taken transaction");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == ST_FULL)
         |-> $past(count_ff) == COUNT_WIDTH'(DEPTH))
      else $error("full refusal while space remained");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= COUNT_WIDTH'(2)) |-> ent[0].prio >= ent[1].prio)
      else $error("head entry out of order");
`endif

endmodule
